// ----- hdl/emsg_pkg.sv -----
// Shared types and constants for the energy meter surge guard.
package emsg_pkg;

  // Fixed field widths of the channel payloads.
  localparam int unsigned CodeW   = 10;
  localparam int unsigned PassW   = 32;
  localparam int unsigned PowerW  = 13;
  localparam int unsigned VoltsW  = 8;
  localparam int unsigned EnergyW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  // Register reset values.
  localparam logic [PassW-1:0]   PasswordReset   = 32'h3132_3334;
  localparam logic [PowerW-1:0]  StandbyReset    = 13'd200;
  localparam logic [EnergyW-1:0] AlarmReset      = 31'd100000;
  localparam logic [EnergyW-1:0] EnergyMax       = 31'h7FFF_FFFF;

  // Alert LED patterns for each surge class.
  localparam logic [3:0] LedSurge5  = 4'h1;
  localparam logic [3:0] LedSurge10 = 4'h3;
  localparam logic [3:0] LedSurge15 = 4'h7;
  localparam logic [3:0] LedSurge25 = 4'hF;

  // Number of ticks the alert LEDs are held after a surge.
  localparam logic [1:0] HoldTicks = 2'd2;

  // Load LED codes: bit 0 standby, bit 1 normal.
  localparam logic [1:0] LoadOff     = 2'b00;
  localparam logic [1:0] LoadStandby = 2'b01;
  localparam logic [1:0] LoadNormal  = 2'b10;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_UNLOCK = 2'd2
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PASSWORD = 2'd0,
    REG_STANDBY  = 2'd1,
    REG_ALARM    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CodeW-1:0] current_code;
    logic [CodeW-1:0] voltage_code;
    logic [PassW-1:0] pass_attempt;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         alert_led_mask;
    logic               standby_led;
    logic               normal_led;
    logic               relay_on;
    logic               is_locked;
    logic [PowerW-1:0]  power_watts;
    logic [VoltsW-1:0]  volts_out;
    logic [EnergyW-1:0] energy_total;
    logic               energy_alarm;
    logic               password_match;
  } out_item_t;

endpackage

// ----- hdl/emsg_ifs.sv -----
// Channel interfaces: input items, result items and configuration writes.
interface emsg_in_if;
  import emsg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface emsg_out_if;
  import emsg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface emsg_cfg_if;
  import emsg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/energy_meter_surge_guard.sv -----
// Top level of the energy meter surge guard.
//
// Channels: in_i takes one transaction per item (ADC sample pair, one-second
// tick or unlock attempt); out_o returns exactly one result transaction per
// item, in order; cfg_i writes the password, the standby power limit and the
// energy alarm limit, and is always ready.
// Latency: the result of an item is valid on out_o in the cycle after the
// item is accepted, unless an earlier result still waits there; then it
// follows in the cycle after the sink takes that one. Throughput: one item
// per cycle while skid is empty, set by the single meter state register stage.
// A two-entry output stage (result register plus skid register) keeps
// in_i ready while one result waits; in_i drops ready only once both hold
// results, and takes items again in the cycle after the sink drains one.
// Reset: all meter state clears, the relay reads closed, the block is
// unlocked, and the registers return to password "1234", a 200 W standby
// limit and a 100000 Ws alarm limit. No results are pending after reset.
module energy_meter_surge_guard
  import emsg_pkg::*;
#(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  emsg_cfg_if.sink   cfg_i,
  emsg_in_if.sink    in_i,
  emsg_out_if.source out_o
);

  localparam int unsigned FsInt = (1 << ADC_BITS) - 1;
  localparam int unsigned ScW   = ADC_BITS + 6;
  localparam logic [ScW-1:0] Thr5  = ScW'(5 * FsInt);
  localparam logic [ScW-1:0] Thr10 = ScW'(10 * FsInt);
  localparam logic [ScW-1:0] Thr15 = ScW'(15 * FsInt);
  localparam logic [ScW-1:0] Thr25 = ScW'(25 * FsInt);

  // Configuration registers.
  logic [PassW-1:0]   password_q;
  logic [PowerW-1:0]  standby_lim_q;
  logic [EnergyW-1:0] alarm_lim_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      password_q    <= PasswordReset;
      standby_lim_q <= StandbyReset;
      alarm_lim_q   <= AlarmReset;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PASSWORD: password_q    <= cfg_i.data;
        REG_STANDBY:  standby_lim_q <= cfg_i.data[PowerW-1:0];
        REG_ALARM:    alarm_lim_q   <= cfg_i.data[EnergyW-1:0];
        default: ;
      endcase
    end
  end

  // Meter state.
  logic [ADC_BITS-1:0] last_cc_q, last_cc_d;
  logic [VoltsW-1:0]   volts_q, volts_d;
  logic [PowerW-1:0]   power_q, power_d;
  logic [EnergyW-1:0]  energy_q, energy_d;
  logic                lock_q, lock_d;
  logic                relay_q, relay_d;
  logic [3:0]          led_q, led_d;
  logic [1:0]          hold_cnt_q, hold_cnt_d;
  logic                hold_act_q, hold_act_d;
  logic [1:0]          load_q, load_d;
  logic                match;

  logic      skid_full;
  logic      accept;
  out_item_t result;

  assign in_i.ready = !skid_full;
  assign accept     = in_i.valid && in_i.ready;

  // Codes are masked to the converter width.
  logic [ADC_BITS-1:0] cur_code;
  logic [ADC_BITS-1:0] volt_code;
  logic [VoltsW-1:0]   conv_volts;
  logic [PowerW-1:0]   conv_power;

  assign cur_code  = ADC_BITS'(in_i.data.current_code);
  assign volt_code = ADC_BITS'(in_i.data.voltage_code);

  emsg_conv #(
    .AdcBits(ADC_BITS)
  ) u_conv (
    .current_i(cur_code),
    .voltage_i(volt_code),
    .volts_o  (conv_volts),
    .power_o  (conv_power)
  );

  // Current step against the previous sample, scaled to amps times full scale.
  logic [ADC_BITS-1:0] step;
  logic [ScW-1:0]      step_scaled;

  assign step        = (cur_code >= last_cc_q) ? cur_code - last_cc_q : last_cc_q - cur_code;
  assign step_scaled = ScW'(step) * ScW'(40);

  // Energy add with saturation at the top of the 31-bit range.
  logic [EnergyW:0] energy_sum;
  assign energy_sum = {1'b0, energy_q} + (EnergyW+1)'(power_q);

  // Next state for the item at the input.
  always_comb begin
    last_cc_d  = last_cc_q;
    volts_d    = volts_q;
    power_d    = power_q;
    energy_d   = energy_q;
    lock_d     = lock_q;
    relay_d    = relay_q;
    led_d      = led_q;
    hold_cnt_d = hold_cnt_q;
    hold_act_d = hold_act_q;
    load_d     = load_q;
    match      = 1'b0;
    case (opcode_e'(in_i.data.opcode))
      OP_SAMPLE: begin
        if (!lock_q) begin
          last_cc_d = cur_code;
          volts_d   = conv_volts;
          power_d   = conv_power;
          if (step_scaled > Thr5) begin
            if (step_scaled >= Thr25) begin
              led_d   = LedSurge25;
              relay_d = 1'b0;
              lock_d  = 1'b1;
            end else if (step_scaled >= Thr15) begin
              led_d = LedSurge15;
            end else if (step_scaled >= Thr10) begin
              led_d = LedSurge10;
            end else begin
              led_d = LedSurge5;
            end
            hold_cnt_d = HoldTicks;
            hold_act_d = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (!lock_q) begin
          energy_d = energy_sum[EnergyW] ? EnergyMax : energy_sum[EnergyW-1:0];
          if (power_q <= standby_lim_q && power_q > PowerW'(1)) begin
            load_d = LoadNormal;
          end else if (power_q >= standby_lim_q) begin
            load_d = LoadStandby;
          end else begin
            load_d = LoadOff;
          end
          if (hold_act_q) begin
            if (hold_cnt_q != 2'd0) begin
              hold_cnt_d = hold_cnt_q - 2'd1;
            end else begin
              led_d      = 4'h0;
              hold_act_d = 1'b0;
            end
          end
        end
      end
      OP_UNLOCK: begin
        if (in_i.data.pass_attempt == password_q) begin
          match   = 1'b1;
          lock_d  = 1'b0;
          relay_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cc_q  <= '0;
      volts_q    <= '0;
      power_q    <= '0;
      energy_q   <= '0;
      lock_q     <= 1'b0;
      relay_q    <= 1'b1;
      led_q      <= 4'h0;
      hold_cnt_q <= 2'd0;
      hold_act_q <= 1'b0;
      load_q     <= LoadOff;
    end else if (accept) begin
      last_cc_q  <= last_cc_d;
      volts_q    <= volts_d;
      power_q    <= power_d;
      energy_q   <= energy_d;
      lock_q     <= lock_d;
      relay_q    <= relay_d;
      led_q      <= led_d;
      hold_cnt_q <= hold_cnt_d;
      hold_act_q <= hold_act_d;
      load_q     <= load_d;
    end
  end

  // Result transaction reflects the state after the update.
  always_comb begin
    result.alert_led_mask = led_d;
    result.standby_led    = load_d[0];
    result.normal_led     = load_d[1];
    result.relay_on       = relay_d;
    result.is_locked      = lock_d;
    result.power_watts    = power_d;
    result.volts_out      = volts_d;
    result.energy_total   = energy_d;
    result.energy_alarm   = energy_d > alarm_lim_q;
    result.password_match = match;
  end

  emsg_skid u_skid (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(accept),
    .item_i(result),
    .full_o(skid_full),
    .out_o (out_o)
  );

endmodule

// ----- hdl/emsg_conv.sv -----
// ADC code conversion: whole volts and power from one sample pair.
module emsg_conv
  import emsg_pkg::*;
#(
  parameter int unsigned AdcBits = 10
) (
  input  logic [AdcBits-1:0] current_i,
  input  logic [AdcBits-1:0] voltage_i,
  output logic [VoltsW-1:0]  volts_o,
  output logic [PowerW-1:0]  power_o
);

  localparam logic [AdcBits:0] Fs = (AdcBits+1)'((1 << AdcBits) - 1);

  // Whole amps = floor(code * 40 / Fs). Fs is 2^N - 1, so the quotient is the
  // high part plus one correction step on the folded remainder.
  logic [AdcBits+5:0] amp_prod;
  logic [5:0]         amp_q0;
  logic [AdcBits:0]   amp_rem;
  logic [5:0]         amps;

  assign amp_prod = (AdcBits+6)'(current_i) * (AdcBits+6)'(40);
  assign amp_q0   = amp_prod[AdcBits+5:AdcBits];
  assign amp_rem  = (AdcBits+1)'(amp_prod[AdcBits-1:0]) + (AdcBits+1)'(amp_q0);
  assign amps     = amp_q0 + ((amp_rem >= Fs) ? 6'd1 : 6'd0);

  // Volts offset = floor((10 * code + Fs) / (2 * Fs)), same folding scheme.
  logic [AdcBits+3:0] volt_num;
  logic [3:0]         volt_q0;
  logic [AdcBits:0]   volt_rem;
  logic [3:0]         volt_q;

  assign volt_num = (AdcBits+4)'(voltage_i) * (AdcBits+4)'(10) + (AdcBits+4)'(Fs);
  assign volt_q0  = volt_num[AdcBits+3:AdcBits];
  assign volt_rem = (AdcBits+1)'(volt_num[AdcBits-1:0]) + (AdcBits+1)'(volt_q0);
  assign volt_q   = volt_q0 + ((volt_rem >= Fs) ? 4'd1 : 4'd0);

  // A zero code means the line is dead.
  assign volts_o = (voltage_i == '0) ? '0 : VoltsW'(8'd123 + VoltsW'(volt_q[3:1]));

  // Power in watts from whole amps and volts.
  logic [13:0] power_full;
  assign power_full = 14'(amps) * 14'(volts_o);
  assign power_o    = power_full[PowerW-1:0];

endmodule

// ----- hdl/emsg_skid.sv -----
// Output register with a skid stage so the input side waits on the sink only when both are full.
module emsg_skid
  import emsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  emsg_out_if.source out_o
);

  logic      out_valid_q;
  out_item_t out_q;
  logic      skid_valid_q;
  out_item_t skid_q;

  // Control: the skid entry drains first, new results go straight out when free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_o.ready) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_o.ready) begin
        skid_q <= item_i;
      end else begin
        out_q <= item_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ----- dv/energy_meter_surge_guard_checker.sv -----
// Checker that predicts and compares every result of the energy meter surge guard.
`timescale 1ns / 100ps

module energy_meter_surge_guard_checker
  import emsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  emsg_cfg_if        cfg_mon_i,
  emsg_in_if         in_mon_i,
  emsg_out_if        out_mon_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  // Conversion constants: full-scale code, amps at full scale, voltage offset and span.
  localparam int unsigned FullScale = (1 << CodeW) - 1;
  localparam int unsigned AmpsFull  = 40;
  localparam int unsigned VoltsBase = 123;
  localparam int unsigned VoltsSpan = 5;

  // Current step classes in whole amps.
  localparam int unsigned StepMinorA = 5;
  localparam int unsigned StepMidA   = 10;
  localparam int unsigned StepMajorA = 15;
  localparam int unsigned StepTripA  = 25;

  // Registers as last written.
  logic [PassW-1:0]   pass_reg;
  logic [PowerW-1:0]  standby_limit;
  logic [EnergyW-1:0] alarm_limit;

  // Meter state.
  logic [CodeW-1:0]   prev_code;
  logic [CodeW-1:0]   present_code;
  logic [VoltsW-1:0]  present_volts;
  logic [EnergyW-1:0] energy_ws;
  logic               locked;
  logic               relay_closed;
  logic [3:0]         alert_mask;
  logic [1:0]         hold_ticks;
  logic               hold_on;
  logic [1:0]         load_ind;

  // Results predicted for accepted items, oldest first.
  out_item_t results_due[$];
  out_item_t oldest;

  function automatic int unsigned volts_of_code(logic [CodeW-1:0] code);
    if (code == '0) begin
      return 0;
    end
    // Rounds half up; a tie cannot occur with an odd full scale.
    return VoltsBase + (2 * VoltsSpan * code + FullScale) / (2 * FullScale);
  endfunction

  function automatic int unsigned meter_power();
    return ((present_code * AmpsFull) / FullScale) * present_volts;
  endfunction

  // An ADC sample: store it and classify the current step against the previous one.
  function automatic void apply_sample(in_item_t item);
    int unsigned step_x40;
    present_code  = item.current_code;
    present_volts = VoltsW'(volts_of_code(item.voltage_code));
    step_x40 = AmpsFull * ((item.current_code >= prev_code) ?
                           item.current_code - prev_code : prev_code - item.current_code);
    if (step_x40 > StepMinorA * FullScale) begin
      if (step_x40 >= StepTripA * FullScale) begin
        alert_mask   = LedSurge25;
        relay_closed = 1'b0;
        locked       = 1'b1;
      end else if (step_x40 >= StepMajorA * FullScale) begin
        alert_mask = LedSurge15;
      end else if (step_x40 >= StepMidA * FullScale) begin
        alert_mask = LedSurge10;
      end else begin
        alert_mask = LedSurge5;
      end
      hold_ticks = HoldTicks;
      hold_on    = 1'b1;
    end
    prev_code = item.current_code;
  endfunction

  // A one-second tick: integrate energy, set the load LEDs, age the alert hold.
  function automatic void apply_tick();
    int unsigned watts;
    watts = meter_power();
    if (energy_ws > EnergyMax - watts) begin
      energy_ws = EnergyMax;
    end else begin
      energy_ws = EnergyW'(energy_ws + watts);
    end
    if (watts <= standby_limit && watts > 1) begin
      load_ind = LoadNormal;
    end else if (watts >= standby_limit) begin
      load_ind = LoadStandby;
    end else begin
      load_ind = LoadOff;
    end
    if (hold_on) begin
      if (hold_ticks != 0) begin
        hold_ticks = hold_ticks - 1'b1;
      end else begin
        alert_mask = '0;
        hold_on    = 1'b0;
      end
    end
  endfunction

  // Advances the meter by one item and returns the result it should produce.
  function automatic out_item_t meter_step(in_item_t item);
    out_item_t   res;
    logic        matched;
    int unsigned watts;
    matched = 1'b0;
    case (item.opcode)
      OP_SAMPLE: begin
        if (!locked) apply_sample(item);
      end
      OP_TICK: begin
        if (!locked) apply_tick();
      end
      OP_UNLOCK: begin
        if (item.pass_attempt == pass_reg) begin
          matched      = 1'b1;
          locked       = 1'b0;
          relay_closed = 1'b1;
        end
      end
      default: ;
    endcase
    watts = meter_power();
    res.alert_led_mask = alert_mask;
    res.standby_led    = load_ind[0];
    res.normal_led     = load_ind[1];
    res.relay_on       = relay_closed;
    res.is_locked      = locked;
    res.power_watts    = PowerW'(watts);
    res.volts_out      = present_volts;
    res.energy_total   = energy_ws;
    res.energy_alarm   = energy_ws > alarm_limit;
    res.password_match = matched;
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Results are checked before the item of the same edge is predicted; a result
  // can never belong to an item accepted at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_reg      = PasswordReset;
      standby_limit = StandbyReset;
      alarm_limit   = AlarmReset;
      prev_code     = '0;
      present_code  = '0;
      present_volts = '0;
      energy_ws     = '0;
      locked        = 1'b0;
      relay_closed  = 1'b1;
      alert_mask    = '0;
      hold_ticks    = '0;
      hold_on       = 1'b0;
      load_ind      = LoadOff;
      results_due.delete();
    end else begin
      // Result transaction.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (results_due.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result with no item pending, expected none, got %h",
                   $time, out_mon_i.data);
        end else begin
          oldest = results_due.pop_front();
          check_field("alert_led_mask", oldest.alert_led_mask, out_mon_i.data.alert_led_mask);
          check_field("standby_led", oldest.standby_led, out_mon_i.data.standby_led);
          check_field("normal_led", oldest.normal_led, out_mon_i.data.normal_led);
          check_field("relay_on", oldest.relay_on, out_mon_i.data.relay_on);
          check_field("is_locked", oldest.is_locked, out_mon_i.data.is_locked);
          check_field("power_watts", oldest.power_watts, out_mon_i.data.power_watts);
          check_field("volts_out", oldest.volts_out, out_mon_i.data.volts_out);
          check_field("energy_total", oldest.energy_total, out_mon_i.data.energy_total);
          check_field("energy_alarm", oldest.energy_alarm, out_mon_i.data.energy_alarm);
          check_field("password_match", oldest.password_match,
                      out_mon_i.data.password_match);
        end
      end
      // Register write transaction.
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          REG_PASSWORD: pass_reg = cfg_mon_i.data;
          REG_STANDBY:  standby_limit = cfg_mon_i.data[PowerW-1:0];
          REG_ALARM:    alarm_limit = cfg_mon_i.data[EnergyW-1:0];
          default: ;
        endcase
      end
      // Input transaction.
      if (in_mon_i.valid && in_mon_i.ready) begin
        results_due.push_back(meter_step(in_mon_i.data));
      end
    end
    pending_o = results_due.size();
  end

endmodule

// ----- dv/energy_meter_surge_guard_test.sv -----
// Testbench top: clock, reset, stimulus and verdict for the energy meter surge guard.
`timescale 1ns / 100ps

module energy_meter_surge_guard_test;
  import emsg_pkg::*;

  localparam logic [1:0] OpUndefined   = 2'd3;
  localparam int         PressureCycles = 200;
  localparam int         QuietLimit     = 5000;
  localparam int         FullLoadTicks  = 20;

  logic clk_i;
  logic rst_ni;

  emsg_cfg_if cfg_ch ();
  emsg_in_if  in_ch ();
  emsg_out_if out_ch ();

  int mismatch_count;
  int pending_results;

  // Random idling on both sides, and requests for a long receiver hold-off.
  bit gaps_on;
  int stalls_requested;

  logic [PassW-1:0] pass_now;
  int               last_code;
  int               op_count[4];

  energy_meter_surge_guard dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  energy_meter_surge_guard_checker checker_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_mon_i       (cfg_ch),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one item, with random gaps ahead of it, and returns at the accepting edge.
  task automatic offer(logic [1:0] op, logic [CodeW-1:0] cc, logic [CodeW-1:0] vc,
                       logic [PassW-1:0] pw);
    in_item_t it;
    it.opcode       = op;
    it.current_code = cc;
    it.voltage_code = vc;
    it.pass_attempt = pw;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    op_count[op]++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDatW-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_PASSWORD) pass_now = value;
  endtask

  // Stops offering items and waits until every predicted result has arrived.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Mostly plausible sample sequences with steps in every surge class, plus
  // ticks, unlock attempts and the undefined opcode.
  task automatic run_random(int count);
    int               roll;
    int               step;
    int               target;
    logic [CodeW-1:0] cc;
    logic [CodeW-1:0] vc;
    logic [PassW-1:0] pw;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      cc   = CodeW'($urandom_range(0, 1023));
      vc   = CodeW'($urandom_range(0, 1023));
      pw   = $urandom;
      if (roll < 42) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: step = $urandom_range(0, 127);
          5:             step = $urandom_range(128, 255);
          6:             step = $urandom_range(256, 383);
          7:             step = $urandom_range(384, 639);
          8:             step = $urandom_range(640, 1023);
          default:       step = -1;
        endcase
        if (step >= 0) begin
          target = $urandom_range(0, 1) ? last_code + step : last_code - step;
          if (target < 0) target = 0;
          if (target > 1023) target = 1023;
          cc = CodeW'(target);
        end
        if ($urandom_range(0, 9) == 0) vc = '0;
        last_code = cc;
        offer(OP_SAMPLE, cc, vc, pw);
      end else if (roll < 78) begin
        offer(OP_TICK, cc, vc, pw);
      end else if (roll < 97) begin
        if ($urandom_range(0, 3) != 0) begin
          pw = pass_now;
        end else if ($urandom_range(0, 1) != 0) begin
          pw = pass_now ^ (32'd1 << $urandom_range(0, 31));
        end
        offer(OP_UNLOCK, cc, vc, pw);
      end else begin
        offer(OpUndefined, cc, vc, pw);
      end
    end
  endtask

  // Result side: random ready, or a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    int stalls_served;
    hold_left     = 0;
    stalls_served = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stalls_served != stalls_requested) begin
        stalls_served++;
        hold_left = PressureCycles;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 38);
      end
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
    $display("energy_meter_surge_guard_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data       = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_PASSWORD;
    cfg_ch.data      = '0;
    gaps_on          = 1'b1;
    stalls_requested = 0;
    pass_now         = PasswordReset;
    last_code        = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset register values: step class boundaries,
    // lock and unlock, ignored items while locked, the undefined opcode.
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_UNLOCK, 10'd0, 10'd0, PasswordReset ^ 32'd7);
    offer(OP_UNLOCK, 10'd0, 10'd0, PasswordReset);
    offer(OP_SAMPLE, 10'd26, 10'd1, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_SAMPLE, 10'd154, 10'd1023, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_SAMPLE, 10'd281, 10'd0, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_SAMPLE, 10'd537, 10'd512, 32'd0);
    offer(OP_SAMPLE, 10'd921, 10'd700, 32'd0);
    offer(OP_SAMPLE, 10'd282, 10'd300, 32'd0);
    offer(OP_SAMPLE, 10'd922, 10'd1023, 32'd0);
    offer(OP_SAMPLE, 10'd0, 10'd0, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OpUndefined, 10'd0, 10'd0, 32'd0);
    offer(OP_UNLOCK, 10'd0, 10'd0, ~PasswordReset);
    offer(OP_UNLOCK, 10'd0, 10'd0, PasswordReset);
    offer(OP_SAMPLE, 10'd1023, 10'd1023, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_SAMPLE, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    offer(OpUndefined, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    offer(OP_UNLOCK, 10'd1023, 10'd1023, PasswordReset);
    last_code = 0;
    drain();

    // Zero limits: standby at no load, alarm as soon as any energy is stored.
    write_reg(REG_PASSWORD, 32'hFFFF_FFFF);
    write_reg(REG_STANDBY, 32'd0);
    write_reg(REG_ALARM, 32'd0);
    run_random(380);
    drain();

    // Top limits and no idling on either side.
    gaps_on = 1'b0;
    write_reg(REG_PASSWORD, 32'd0);
    write_reg(REG_STANDBY, 32'd5120);
    write_reg(REG_ALARM, {1'b0, EnergyMax});
    run_random(380);
    drain();

    // Random limits with a long output hold-off that backs up the input.
    gaps_on = 1'b1;
    write_reg(REG_PASSWORD, $urandom);
    write_reg(REG_STANDBY, $urandom_range(0, 5120));
    write_reg(REG_ALARM, $urandom_range(0, 2000000));
    @(posedge clk_i);
    stalls_requested++;
    run_random(380);
    drain();

    write_reg(REG_PASSWORD, $urandom);
    write_reg(REG_STANDBY, $urandom_range(0, 5120));
    write_reg(REG_ALARM, $urandom_range(0, 5000000));
    run_random(380);
    drain();

    write_reg(REG_PASSWORD, PasswordReset);
    write_reg(REG_STANDBY, StandbyReset);
    write_reg(REG_ALARM, AlarmReset);
    run_random(380);
    drain();

    // A run of full load ticks, then the alarm at its top limit.
    gaps_on = 1'b0;
    offer(OP_UNLOCK, 10'd0, 10'd0, pass_now);
    offer(OP_SAMPLE, 10'd1023, 10'd1023, 32'd0);
    offer(OP_UNLOCK, 10'd0, 10'd0, pass_now);
    for (int n = 0; n < FullLoadTicks; n++) begin
      offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    end
    drain();
    write_reg(REG_ALARM, {1'b0, EnergyMax});
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    offer(OP_TICK, 10'd0, 10'd0, 32'd0);
    drain();

    $display("Covered %0d samples, %0d ticks, %0d unlock attempts and %0d undefined items",
             op_count[OP_SAMPLE], op_count[OP_TICK], op_count[OP_UNLOCK],
             op_count[OpUndefined]);
    $display("under six register settings, a long output stall and full load ticks.");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("energy_meter_surge_guard_test OK");
    end else begin
      $display("energy_meter_surge_guard_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- energy_meter_surge_guard.f -----
hdl/emsg_pkg.sv
hdl/emsg_ifs.sv
hdl/emsg_conv.sv
hdl/emsg_skid.sv
hdl/energy_meter_surge_guard.sv
dv/energy_meter_surge_guard_checker.sv
dv/energy_meter_surge_guard_test.sv
